FILE: hw/rtl/m4v4_pkg.sv
// Shared types, constants and helper functions for the 4x4 matrix-vector transform.
// No dependencies; every other file in hw/rtl imports this package.
package m4v4_pkg;

  localparam logic [31:0] QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] EXP_INF  = 32'h7F80_0000;

  // Unrounded value: sig * 2^(e-150), or a finished special result
  typedef struct packed {
    logic               spec;
    logic [31:0]        sval;
    logic               sign;
    logic signed [13:0] e;
    logic [63:0]        sig;
  } m4v4_unr_t;

  function automatic logic f_is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic f_is_inf(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
  endfunction

  function automatic logic f_is_zero(input logic [31:0] a);
    return a[30:0] == 31'd0;
  endfunction

  // significand with hidden bit; subnormals get none
  function automatic logic [23:0] f_sig(input logic [31:0] a);
    return {(a[30:23] != 8'd0), a[22:0]};
  endfunction

  // biased exponent, subnormals read as 1
  function automatic logic [7:0] f_bexp(input logic [31:0] a);
    return (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
  endfunction

endpackage

FILE: hw/rtl/m4v4_round.sv
// Three-stage normalize and round to binary32, ties to even.
// Depends on m4v4_pkg.
module m4v4_round
  import m4v4_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  m4v4_unr_t   unr,
  output logic [31:0] res
);

  // stage 1: leading one search, exponent and shift amount
  logic               spec1_r, sign1_r;
  logic [31:0]        sval1_r;
  logic [63:0]        sig1_r;
  logic [10:0]        eeff1_r;
  logic signed [13:0] rs1_r;

  logic [5:0]         p;
  logic signed [13:0] ex, eeff;

  always_comb begin
    p = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (unr.sig[i]) p = 6'(i);
    end
    ex   = unr.e + $signed({8'd0, p}) - 14'sd23;
    eeff = (ex < 14'sd1) ? 14'sd1 : ex;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spec1_r <= unr.spec;
      sval1_r <= unr.sval;
      sign1_r <= unr.sign;
      sig1_r  <= unr.sig;
      eeff1_r <= eeff[10:0];
      rs1_r   <= eeff - unr.e;
    end
  end

  // stage 2: align significand, keep guard and sticky
  logic        spec2_r, sign2_r, g2_r, s2_r;
  logic [31:0] sval2_r;
  logic [10:0] eeff2_r;
  logic [23:0] m2_r;

  logic [13:0]  nl;
  logic [63:0]  lsh;
  logic [127:0] wide;
  logic [23:0]  m_nxt;
  logic         g_nxt, s_nxt;

  always_comb begin
    nl   = 14'(-rs1_r);
    lsh  = sig1_r << nl[5:0];
    wide = {sig1_r, 64'd0} >> rs1_r[6:0];
    if (rs1_r <= 14'sd0) begin
      m_nxt = lsh[23:0];
      g_nxt = 1'b0;
      s_nxt = 1'b0;
    end else if (rs1_r > 14'sd64) begin
      m_nxt = 24'd0;
      g_nxt = 1'b0;
      s_nxt = 1'b1;
    end else begin
      m_nxt = wide[87:64];
      g_nxt = wide[63];
      s_nxt = |wide[62:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spec2_r <= spec1_r;
      sval2_r <= sval1_r;
      sign2_r <= sign1_r;
      eeff2_r <= eeff1_r;
      m2_r    <= m_nxt;
      g2_r    <= g_nxt;
      s2_r    <= s_nxt;
    end
  end

  // stage 3: increment, pack, saturate to infinity
  logic        inc;
  logic [34:0] bits;
  logic [31:0] res_nxt;
  logic [31:0] res_r;

  always_comb begin
    inc  = g2_r & (s2_r | m2_r[0]);
    bits = {1'b0, eeff2_r - 11'd1, 23'd0} + {11'd0, m2_r} + {34'd0, inc};
    if (spec2_r) begin
      res_nxt = sval2_r;
    end else if (bits >= {3'd0, EXP_INF}) begin
      res_nxt = {sign2_r, EXP_INF[30:0]};
    end else begin
      res_nxt = {sign2_r, bits[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

FILE: hw/rtl/m4v4_fmul.sv
// Four-stage binary32 multiplier: special cases and 24x24 product, then rounding.
// Depends on m4v4_pkg and m4v4_round.
module m4v4_fmul
  import m4v4_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] res
);

  m4v4_unr_t   unr_nxt, unr_r;
  logic        sign;
  logic [23:0] ma, mb;
  logic [47:0] mprod;

  always_comb begin
    sign         = a[31] ^ b[31];
    ma           = f_sig(a);
    mb           = f_sig(b);
    // full 48-bit product
    mprod        = ma * mb;
    unr_nxt.sign = sign;
    unr_nxt.e    = $signed({6'd0, f_bexp(a)}) + $signed({6'd0, f_bexp(b)}) - 14'sd150;
    unr_nxt.sig  = {16'd0, mprod};
    unr_nxt.spec = 1'b1;
    if (f_is_nan(a) || f_is_nan(b)) begin
      unr_nxt.sval = QNAN;
    end else if (f_is_inf(a) || f_is_inf(b)) begin
      unr_nxt.sval = (f_is_zero(a) || f_is_zero(b)) ? QNAN : {sign, EXP_INF[30:0]};
    end else if (f_is_zero(a) || f_is_zero(b)) begin
      unr_nxt.sval = {sign, 31'd0};
    end else begin
      unr_nxt.spec = 1'b0;
      unr_nxt.sval = QNAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) unr_r <= unr_nxt;
  end

  m4v4_round u_round (
    .clk (clk),
    .en  (en),
    .unr (unr_r),
    .res (res)
  );

endmodule

FILE: hw/rtl/m4v4_fadd.sv
// Four-stage binary32 adder: special cases, swap, align and add, then rounding.
// Depends on m4v4_pkg and m4v4_round.
module m4v4_fadd
  import m4v4_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] res
);

  m4v4_unr_t unr_nxt, unr_r;

  logic [31:0]  big, sml;
  logic [7:0]   eb, d;
  logic [49:0]  xb, xs;
  logic [99:0]  wide;
  logic [50:0]  sum;
  logic         sgn;

  always_comb begin
    if (f_bexp(b) > f_bexp(a)) begin
      big = b;
      sml = a;
    end else begin
      big = a;
      sml = b;
    end
    eb   = f_bexp(big);
    d    = eb - f_bexp(sml);
    xb   = {f_sig(big), 26'd0};
    wide = {f_sig(sml), 26'd0, 50'd0} >> d;
    // far-below operands only leave a sticky bit
    if (d >= 8'd50) begin
      xs = 50'd1;
    end else begin
      xs = wide[99:50] | {49'd0, |wide[49:0]};
    end
    if (big[31] == sml[31]) begin
      sum = {1'b0, xb} + {1'b0, xs};
      sgn = big[31];
    end else if (xb >= xs) begin
      sum = {1'b0, xb - xs};
      sgn = big[31];
    end else begin
      sum = {1'b0, xs - xb};
      sgn = sml[31];
    end

    unr_nxt.sign = sgn;
    unr_nxt.e    = $signed({6'd0, eb}) - 14'sd26;
    unr_nxt.sig  = {13'd0, sum};
    unr_nxt.spec = 1'b1;
    if (f_is_nan(a) || f_is_nan(b)) begin
      unr_nxt.sval = QNAN;
    end else if (f_is_inf(a) && f_is_inf(b)) begin
      unr_nxt.sval = (a[31] == b[31]) ? a : QNAN;
    end else if (f_is_inf(a)) begin
      unr_nxt.sval = a;
    end else if (f_is_inf(b)) begin
      unr_nxt.sval = b;
    end else if (f_is_zero(a) && f_is_zero(b)) begin
      unr_nxt.sval = {a[31] & b[31], 31'd0};
    end else if (f_is_zero(a)) begin
      unr_nxt.sval = b;
    end else if (f_is_zero(b)) begin
      unr_nxt.sval = a;
    end else if (sum == 51'd0) begin
      unr_nxt.sval = 32'd0;
    end else begin
      unr_nxt.spec = 1'b0;
      unr_nxt.sval = QNAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) unr_r <= unr_nxt;
  end

  m4v4_round u_round (
    .clk (clk),
    .en  (en),
    .unr (unr_r),
    .res (res)
  );

endmodule

FILE: hw/rtl/mat4_vec4_transform.sv
// Column-major 4x4 binary32 matrix times a binary32 vector, one vector per cycle
// unless held. Pipeline: 4 multiply stages, then three chained adds of 4 stages each.
// The whole pipe advances together; it holds only while a result waits unaccepted.
// Reset (synchronous, rst_n low) clears all valid bits and loads the identity matrix.
// Depends on m4v4_pkg, m4v4_fmul, m4v4_fadd.
module mat4_vec4_transform
  import m4v4_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // vec_x, vec_y, vec_z, vec_w from bit 0 up
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // res_x, res_y, res_z, res_w from bit 0 up
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [5:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int LAT = 16;
  localparam int MULD = 4;

  // Configuration registers: register i at byte address 8*i
  logic [63:0] mat_r [8];
  logic [2:0]  cfg_idx;

  assign cfg_idx    = cfg_paddr[5:3];
  assign cfg_pready = 1'b1;
  assign cfg_prdata = mat_r[cfg_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r[0] <= 64'h0000_0000_3F80_0000;
      mat_r[1] <= 64'd0;
      mat_r[2] <= 64'h3F80_0000_0000_0000;
      mat_r[3] <= 64'd0;
      mat_r[4] <= 64'd0;
      mat_r[5] <= 64'h0000_0000_3F80_0000;
      mat_r[6] <= 64'd0;
      mat_r[7] <= 64'h3F80_0000_0000_0000;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      mat_r[cfg_idx] <= cfg_pwdata;
    end
  end

  // Pipe control: advance every stage unless the output register is held
  logic           en;
  logic [LAT-1:0] vld_r;

  assign en         = !vld_r[LAT-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  logic [31:0] vec [4];
  logic [31:0] prod [4][4];   // [row][column]
  logic [31:0] p2_r [4][MULD];
  logic [31:0] p3_r [4][2*MULD];
  logic [31:0] acc1 [4];
  logic [31:0] acc2 [4];
  logic [31:0] acc3 [4];

  for (genvar k = 0; k < 4; k++) begin : g_vec
    assign vec[k] = in_tdata[32*k +: 32];
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      // element (column c, row r) sits in register 2c + r/2, half r%2
      m4v4_fmul u_mul (
        .clk (clk),
        .en  (en),
        .a   (vec[c]),
        .b   (mat_r[2*c + r/2][32*(r%2) +: 32]),
        .res (prod[r][c])
      );
    end

    // Delay the later products to meet the running sum
    always_ff @(posedge clk) begin
      if (en) begin
        p2_r[r][0] <= prod[r][2];
        p3_r[r][0] <= prod[r][3];
        for (int s = 1; s < MULD; s++) p2_r[r][s] <= p2_r[r][s-1];
        for (int s = 1; s < 2*MULD; s++) p3_r[r][s] <= p3_r[r][s-1];
      end
    end

    m4v4_fadd u_add1 (
      .clk (clk), .en (en), .a (prod[r][1]), .b (prod[r][0]), .res (acc1[r])
    );
    m4v4_fadd u_add2 (
      .clk (clk), .en (en), .a (p2_r[r][MULD-1]), .b (acc1[r]), .res (acc2[r])
    );
    m4v4_fadd u_add3 (
      .clk (clk), .en (en), .a (p3_r[r][2*MULD-1]), .b (acc2[r]), .res (acc3[r])
    );

    // last round register of the third adder is the output register
    assign out_tdata[32*r +: 32] = acc3[r];
  end

endmodule

FILE: bench/mat4_vec4_transform_tb.sv
// Self-checking bench for mat4_vec4_transform: matrix-vector products in binary32.
// Drives the input stream, the result stream and the APB register port of the block.
// Depends on mat4_vec4_transform and the package m4v4_pkg (through the RTL only).
`timescale 1ns / 100ps

module mat4_vec4_transform_tb;

  localparam logic [31:0] F_QNAN = 32'h7FC0_0000;
  localparam logic [31:0] F_PINF = 32'h7F80_0000;
  localparam logic [31:0] F_NINF = 32'hFF80_0000;
  localparam logic [31:0] F_ONE  = 32'h3F80_0000;
  localparam logic [31:0] F_MAXF = 32'h7F7F_FFFF;
  localparam logic [31:0] F_MIND = 32'h0000_0001;
  localparam logic [31:0] F_NZRO = 32'h8000_0000;
  localparam int          HOLD_CYCLES = 80;
  localparam int          DRAIN_CYCLES = 24;

  // x sits in the low bits, matching the tdata layout
  typedef struct packed {
    logic [31:0] w;
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } quad_t;

  typedef struct {
    quad_t vec;
    bit    typed;
    quad_t res;
  } dir_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;    // vec_x, vec_y, vec_z, vec_w from bit 0 up
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;   // res_x, res_y, res_z, res_w from bit 0 up
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [5:0]   cfg_paddr;
  logic [63:0]  cfg_pwdata;
  logic [63:0]  cfg_prdata;
  logic         cfg_pready;

  mat4_vec4_transform i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Bench copy of the matrix registers, updated as each APB write lands
  logic [63:0] mtx_reg [8];
  quad_t       product_q [$];
  int          n_fail;
  int          n_vecs;
  int          n_results;
  int          n_cfg_writes;
  bit          calm;          // no random gaps on either side
  bit          hold_req;      // ask the receiver for a long hold-off
  bit          cur_typed;     // the offered transfer carries a typed-in result
  quad_t       cur_res;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // binary32 arithmetic, round to nearest even, subnormals kept
  // ---------------------------------------------------------------------------
  function automatic bit fnan(logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] != 0;
  endfunction

  function automatic bit finf(logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] == 0;
  endfunction

  function automatic bit fzero(logic [31:0] a);
    return a[30:0] == 0;
  endfunction

  function automatic logic [63:0] mant(logic [31:0] a);
    return {40'd0, a[30:23] != 0, a[22:0]};
  endfunction

  function automatic int bexp(logic [31:0] a);
    return a[30:23] == 0 ? 1 : int'(a[30:23]);
  endfunction

  // value is sig * 2^(e-150); sig nonzero and below 2^63
  function automatic logic [31:0] pack_round(logic sgn, int e, logic [63:0] sig);
    int          p;
    int          ex;
    int          eeff;
    int          rs;
    logic [63:0] m;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] bits;
    p = 63;
    while (p > 0 && !sig[p]) p--;
    ex = e + p - 23;
    eeff = ex < 1 ? 1 : ex;
    rs = eeff - e;
    if (rs <= 0) begin
      m = sig << (-rs);
    end else begin
      if (rs > 63) rs = 63;
      m = sig >> rs;
      rem = sig & ((64'd1 << rs) - 1);
      half = 64'd1 << (rs - 1);
      if (rem > half || (rem == half && m[0])) m++;
    end
    // a carry out of the significand moves into the exponent field
    bits = (64'(eeff - 1) << 23) + m;
    if (bits >= 64'(F_PINF)) bits = 64'(F_PINF);
    return {sgn, 31'd0} | bits[31:0];
  endfunction

  function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
    logic sgn;
    sgn = a[31] ^ b[31];
    if (fnan(a) || fnan(b)) return F_QNAN;
    if (finf(a) || finf(b)) begin
      if (fzero(a) || fzero(b)) return F_QNAN;
      return {sgn, 31'd0} | F_PINF;
    end
    if (fzero(a) || fzero(b)) return {sgn, 31'd0};
    return pack_round(sgn, bexp(a) + bexp(b) - 150, mant(a) * mant(b));
  endfunction

  function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
    logic [31:0] big;
    logic [31:0] sml;
    int          eb;
    int          d;
    logic [63:0] xb;
    logic [63:0] xs;
    logic [63:0] sig;
    logic        sgn;
    if (fnan(a) || fnan(b)) return F_QNAN;
    if (finf(a) && finf(b)) return a[31] == b[31] ? a : F_QNAN;
    if (finf(a)) return a;
    if (finf(b)) return b;
    if (fzero(a) && fzero(b)) return {a[31] & b[31], 31'd0};
    if (fzero(a)) return b;
    if (fzero(b)) return a;
    big = a;
    sml = b;
    if (bexp(b) > bexp(a)) begin
      big = b;
      sml = a;
    end
    eb = bexp(big);
    d = eb - bexp(sml);
    xb = mant(big) << 38;
    // far below half an ulp the smaller operand only acts as a sticky bit
    xs = d <= 38 ? mant(sml) << (38 - d) : 64'd1;
    if (big[31] == sml[31]) begin
      sig = xb + xs;
      sgn = big[31];
    end else if (xb >= xs) begin
      sig = xb - xs;
      sgn = big[31];
    end else begin
      sig = xs - xb;
      sgn = sml[31];
    end
    if (sig == 0) return 32'd0;
    return pack_round(sgn, eb - 38, sig);
  endfunction

  // column-major element: register 2*col + row/2, half picked by row parity
  function automatic logic [31:0] melem(int col, int row);
    logic [63:0] r;
    r = mtx_reg[col * 2 + row / 2];
    return row % 2 ? r[63:32] : r[31:0];
  endfunction

  function automatic quad_t transform(quad_t v);
    logic [31:0] acc [4];
    for (int j = 0; j < 4; j++) begin
      acc[j] = fmul(v.x, melem(0, j));
      acc[j] = fadd(fmul(v.y, melem(1, j)), acc[j]);
      acc[j] = fadd(fmul(v.z, melem(2, j)), acc[j]);
      acc[j] = fadd(fmul(v.w, melem(3, j)), acc[j]);
    end
    return '{w: acc[3], z: acc[2], y: acc[1], x: acc[0]};
  endfunction

  // Operands weighted toward the interesting corners of the format
  function automatic logic [31:0] rand_f32();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(7))
          0: r = 32'd0;
          1: r = F_NZRO;
          2: r = F_PINF;
          3: r = F_NINF;
          4: r = F_MAXF | (r & 32'h8000_0000);
          5: r = F_MIND | (r & 32'h8000_0000);
          6: r = F_ONE | (r & 32'h8000_0000);
          default: r = 32'h7F80_0000 | r;   // NaN, payload random
        endcase
      end
      1: r[30:23] = 8'd0;                                  // subnormal
      2: r[30:23] = 8'($urandom_range(1, 24));             // near underflow
      3: r[30:23] = 8'($urandom_range(230, 254));          // near overflow
      4, 5, 6, 7: r[30:23] = 8'($urandom_range(118, 136)); // cancellation range
      default: ;                                           // any pattern
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checker: predict on every input transfer, compare on every result transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    quad_t want;
    quad_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        product_q.push_back(cur_typed ? cur_res : transform(in_tdata));
        n_vecs++;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        n_results++;
        if (product_q.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, got);
          n_fail++;
        end else begin
          want = product_q.pop_front();
          if (got.x !== want.x) begin
            $display("%0t: res_x expected %h actual %h", $realtime, want.x, got.x);
            n_fail++;
          end
          if (got.y !== want.y) begin
            $display("%0t: res_y expected %h actual %h", $realtime, want.y, got.y);
            n_fail++;
          end
          if (got.z !== want.z) begin
            $display("%0t: res_z expected %h actual %h", $realtime, want.z, got.z);
            n_fail++;
          end
          if (got.w !== want.w) begin
            $display("%0t: res_w expected %h actual %h", $realtime, want.w, got.w);
            n_fail++;
          end
        end
      end
    end
  end

  // Receiver: random back-pressure, a calm stretch, and one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_tready <= calm || $urandom_range(99) >= 27;
    end
  end

  // Offer one vector, idling first at random; return after the transfer
  task automatic offer_vec(quad_t v, bit typed, quad_t res);
    while (!calm && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    cur_typed = typed;
    cur_res   = res;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Idle the input and wait for every product to come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (product_q.size() != 0) @(negedge clk);
  endtask

  // Setup, access, then idle with psel low before the next write
  task automatic apb_write(int idx, logic [63:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 6'(idx * 8);
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    mtx_reg[idx] = val;
    n_cfg_writes++;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // Load a whole matrix; kind picks random, extreme or identity contents
  task automatic load_matrix(int kind);
    logic [63:0] val;
    for (int i = 0; i < 8; i++) begin
      case (kind)
        0: val = {rand_f32(), rand_f32()};
        1: val = {F_MAXF, F_MAXF};
        2: val = {F_MIND, 32'h8000_0001};
        3: val = {32'hFFFF_FFFF, 32'hFFFF_FFFF};
        default: val = (i == 0 || i == 5) ? 64'(F_ONE) :
                       (i == 2 || i == 7) ? {F_ONE, 32'd0} : 64'd0;
      endcase
      apb_write(i, val);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t dir_tab [$];
    quad_t    v;
    int       phase_kind [7];
    int       phase_len;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    cur_typed   = 1'b0;
    cur_res     = '0;
    n_fail      = 0;
    n_vecs      = 0;
    n_results   = 0;
    n_cfg_writes = 0;
    // identity after reset
    mtx_reg = '{64'(F_ONE), 64'd0, {F_ONE, 32'd0}, 64'd0,
                64'd0, 64'(F_ONE), 64'd0, {F_ONE, 32'd0}};

    // Typed rows hold under the identity matrix loaded by reset
    dir_tab.push_back('{'{w: 32'h4080_0000, z: 32'h4040_0000, y: 32'h4000_0000, x: F_ONE}, 1,
                        '{w: 32'h4080_0000, z: 32'h4040_0000, y: 32'h4000_0000, x: F_ONE}});
    dir_tab.push_back('{'{w: 0, z: 0, y: 0, x: 0}, 1, '{w: 0, z: 0, y: 0, x: 0}});
    // NaN in x poisons every lane, through x times one or x times zero
    dir_tab.push_back('{'{w: F_ONE, z: F_ONE, y: F_ONE, x: 32'hFFFF_FFFF}, 1,
                        '{w: F_QNAN, z: F_QNAN, y: F_QNAN, x: F_QNAN}});
    // infinity in x: infinity times zero in the off-diagonal lanes
    dir_tab.push_back('{'{w: F_ONE, z: F_ONE, y: F_ONE, x: F_PINF}, 1,
                        '{w: F_QNAN, z: F_QNAN, y: F_QNAN, x: F_PINF}});
    // negative zero vector: every product is a negative zero
    dir_tab.push_back('{'{w: F_NZRO, z: F_NZRO, y: F_NZRO, x: F_NZRO}, 0, '0});
    dir_tab.push_back('{'{w: F_MAXF, z: F_MIND, y: 32'hFF7F_FFFF, x: 32'h8000_0001}, 0, '0});
    dir_tab.push_back('{'{w: F_NINF, z: F_PINF, y: F_NINF, x: F_PINF}, 0, '0});
    dir_tab.push_back('{'{w: 32'h007F_FFFF, z: 32'h0080_0000, y: 32'h807F_FFFF, x: F_ONE}, 0, '0});
    dir_tab.push_back('{'{w: '1, z: '1, y: '1, x: '1}, 0, '0});

    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) offer_vec(dir_tab[i].vec, dir_tab[i].typed, dir_tab[i].res);
    drain();

    // Extreme matrices: overflow, subnormal products, NaN everywhere
    for (int k = 1; k <= 3; k++) begin
      load_matrix(k);
      for (int i = 0; i < 8; i++) offer_vec(i < 4 ? dir_tab[i + 4].vec : quad_t'(
        {rand_f32(), rand_f32(), rand_f32(), rand_f32()}), 0, '0);
      drain();
    end

    // Random phases: new matrix each, with one calm phase, one long receiver
    // hold-off and one sender pause mid-phase
    phase_kind = '{0, 0, 0, 4, 0, 1, 2};
    foreach (phase_kind[p]) begin
      load_matrix(phase_kind[p]);
      calm = (p == 2);
      phase_len = (phase_kind[p] == 0) ? 270 : 60;
      for (int i = 0; i < phase_len; i++) begin
        if (p == 1 && i == 10) hold_req = 1'b1;
        if (p == 4 && i == 100) drain();
        v = {rand_f32(), rand_f32(), rand_f32(), rand_f32()};
        offer_vec(v, 0, '0);
      end
      drain();
      calm = 1'b0;
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Run covered %0d vectors, %0d results, %0d register writes over 11 matrices.",
             n_vecs, n_results, n_cfg_writes);
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", n_fail);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("Timeout: %0d results still outstanding", product_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
